[design/u8trx_pkg.sv]
// Shared types and constants for the buffered 8N1 UART transceiver.
// No dependencies; used by uart_8n1_transceiver_buffered_core.

package u8trx_pkg;

    localparam int unsigned BUFFER_DEPTH_DEF = 32;
    localparam int unsigned FRAME_LEN        = 10;

    localparam logic [15:0] BIT_PERIOD_RST   = 16'd125;
    localparam logic [15:0] RX_START_RST     = 16'd122;

    localparam int unsigned CFG_IDX_W        = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_START   = 8'd1;

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_EDGE = 2'd1,
        MODE_LOAD = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_RXBYTE = 3'd1,
        EV_RXIDLE = 3'd2,
        EV_TXDONE = 3'd3,
        EV_REJECT = 3'd4
    } t_event;

endpackage

[design/uart_8n1_transceiver_buffered_core.sv]
// Top level of the buffered half-duplex 8N1 UART transceiver.
// Depends on u8trx_pkg and u8trx_txbuf.
//
//  channel   dir  handshake                    payload
//  -------   ---  ---------------------------  --------------------------------------
//  s (in)    in   i_s_tvalid / o_s_tready      tuser=mode, tdata={tx_byte,rx_level}, tlast
//  m (out)   out  o_m_tvalid / i_m_tready      tuser=event, tdata={rx_byte,tx_line}
//  cfg       in   i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
//  One beat in, one beat out: the whole update is a compare against the bit
//  timer and a one-bit shift, so a beat is taken every cycle while the sink
//  is not stalling the output register. The result is registered there; while
//  it is stalled a new beat is still taken in the cycle the sink drains it.
//  The next transmit byte is prefetched from the buffer's registered read port,
//  which is valid well before the nine further bit updates that precede its use.
//  Reset (synchronous, active low) clears control state; the buffer is not
//  cleared, only bytes written by the current burst are ever read.

module uart_8n1_transceiver_buffered_core #(
    parameter int unsigned BUFFER_DEPTH = u8trx_pkg::BUFFER_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [0] rx_level, [8:1] tx_byte, [15:9] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] mode
    input  logic        i_s_tlast,   // tx_last
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [0] tx_line, [8:1] rx_byte, [15:9] zero
    output logic [2:0]  o_m_tuser,   // [2:0] event_res
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [u8trx_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
    localparam logic [3:0] LAST_BIT = 4'(u8trx_pkg::FRAME_LEN - 1);
    localparam logic [3:0] FRAME_C  = 4'(u8trx_pkg::FRAME_LEN);

    // configuration
    logic [15:0] r_bit_period, r_rx_start;

    // core state
    logic [CW-1:0] r_load_cnt,  n_load_cnt;
    logic          r_load_ovf,  n_load_ovf;
    logic [CW-1:0] r_send_len,  n_send_len;
    logic [CW-1:0] r_send_idx,  n_send_idx;
    logic [3:0]    r_bit_pos,   n_bit_pos;
    logic [9:0]    r_frame,     n_frame;
    logic [15:0]   r_tick_cnt,  n_tick_cnt;
    logic          r_timer_run, n_timer_run;
    logic          r_edge_en,   n_edge_en;
    logic          r_line,      n_line;
    logic [7:0]    r_first,     n_first;   // copy of buffer entry 0

    // output register
    logic                r_out_valid;
    u8trx_pkg::t_event   r_out_ev, n_ev;
    logic [7:0]          r_out_rx, n_rx;
    logic                r_out_line;

    // buffer ports
    logic          buf_wr_en;
    logic [AW-1:0] buf_wr_addr;
    logic [AW-1:0] buf_rd_addr;
    logic [7:0]    buf_rd_data;
    logic [CW-1:0] next_idx;

    logic              s_accept;
    u8trx_pkg::t_mode  in_mode;
    logic              in_level;
    logic [7:0]        in_byte;
    logic [15:0]       tick_top;
    logic [3:0]        bp_mod;
    logic              ovf_new;
    logic [CW-1:0]     cnt_new;

    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    assign in_mode  = u8trx_pkg::t_mode'(i_s_tuser);
    assign in_level = i_s_tdata[0];
    assign in_byte  = i_s_tdata[8:1];

    // prefetch the byte after the one on the line
    assign next_idx    = r_send_idx + CW'(1);
    assign buf_rd_addr = (next_idx < DEPTH_C) ? next_idx[AW-1:0] : '0;
    assign buf_wr_addr = r_load_cnt[AW-1:0];

    u8trx_txbuf #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_txbuf (
        .i_clk     (i_clk),
        .i_wr_en   (buf_wr_en),
        .i_wr_addr (buf_wr_addr),
        .i_wr_data (in_byte),
        .i_rd_addr (buf_rd_addr),
        .o_rd_data (buf_rd_data)
    );

    assign tick_top = (r_bit_period == 16'd0) ? 16'd0 : r_bit_period - 16'd1;
    assign bp_mod   = (r_bit_pos >= FRAME_C) ? r_bit_pos - FRAME_C : r_bit_pos;
    assign ovf_new  = r_load_ovf || (r_load_cnt >= DEPTH_C);
    assign cnt_new  = (r_load_cnt < DEPTH_C) ? r_load_cnt + CW'(1) : r_load_cnt;

    always_comb begin
        n_load_cnt  = r_load_cnt;
        n_load_ovf  = r_load_ovf;
        n_send_len  = r_send_len;
        n_send_idx  = r_send_idx;
        n_bit_pos   = r_bit_pos;
        n_frame     = r_frame;
        n_tick_cnt  = r_tick_cnt;
        n_timer_run = r_timer_run;
        n_edge_en   = r_edge_en;
        n_line      = r_line;
        n_first     = r_first;
        n_ev        = u8trx_pkg::EV_NONE;
        n_rx        = 8'd0;
        buf_wr_en   = 1'b0;

        unique case (in_mode)
            u8trx_pkg::MODE_TICK: begin
                if (r_timer_run) begin
                    if (r_tick_cnt >= tick_top) begin
                        n_tick_cnt = 16'd0;
                        if (r_send_len != '0) begin
                            if (r_send_idx != r_send_len) begin
                                n_line = r_frame[bp_mod];
                                if (r_bit_pos >= LAST_BIT) begin
                                    n_bit_pos  = 4'd0;
                                    n_send_idx = next_idx;
                                    if (next_idx < r_send_len && next_idx < DEPTH_C) begin
                                        n_frame = {1'b1, buf_rd_data, 1'b0};
                                    end
                                end else begin
                                    n_bit_pos = r_bit_pos + 4'd1;
                                end
                            end else begin
                                // burst finished
                                n_send_idx  = '0;
                                n_send_len  = '0;
                                n_timer_run = 1'b0;
                                n_edge_en   = 1'b1;
                                n_ev        = u8trx_pkg::EV_TXDONE;
                            end
                        end else begin
                            if (r_bit_pos < FRAME_C) begin
                                n_frame = r_frame | (10'(in_level) << r_bit_pos);
                            end
                            if (r_bit_pos == LAST_BIT) begin
                                n_bit_pos = FRAME_C;
                                n_edge_en = 1'b1;
                                n_rx      = n_frame[8:1];
                                n_ev      = u8trx_pkg::EV_RXBYTE;
                            end else if (r_bit_pos >= FRAME_C) begin
                                // idle slot after the stop bit
                                n_bit_pos   = 4'd0;
                                n_timer_run = 1'b0;
                                n_ev        = u8trx_pkg::EV_RXIDLE;
                            end else begin
                                n_bit_pos = r_bit_pos + 4'd1;
                            end
                        end
                    end else begin
                        n_tick_cnt = r_tick_cnt + 16'd1;
                    end
                end
            end
            u8trx_pkg::MODE_EDGE: begin
                if (r_edge_en) begin
                    n_tick_cnt  = r_rx_start;
                    n_timer_run = 1'b1;
                    n_edge_en   = 1'b0;
                    n_frame     = 10'd0;
                    n_bit_pos   = 4'd0;
                end
            end
            u8trx_pkg::MODE_LOAD: begin
                if (r_send_len == '0) begin
                    if (r_load_cnt < DEPTH_C) begin
                        buf_wr_en = s_accept;
                        if (r_load_cnt == '0) begin
                            n_first = in_byte;
                        end
                    end
                    n_load_cnt = cnt_new;
                    n_load_ovf = ovf_new;
                    if (i_s_tlast) begin
                        if (ovf_new) begin
                            n_ev = u8trx_pkg::EV_REJECT;
                        end else begin
                            n_send_len  = cnt_new;
                            n_send_idx  = '0;
                            n_bit_pos   = 4'd0;
                            n_frame     = {1'b1, n_first, 1'b0};
                            n_edge_en   = 1'b0;
                            n_timer_run = 1'b1;
                        end
                        n_load_cnt = '0;
                        n_load_ovf = 1'b0;
                    end
                end
            end
            default: begin
                // unused mode: no effect
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= u8trx_pkg::BIT_PERIOD_RST;
            r_rx_start   <= u8trx_pkg::RX_START_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == u8trx_pkg::CFG_BIT_PERIOD) begin
                r_bit_period <= i_cfg_data;
            end else if (i_cfg_index == u8trx_pkg::CFG_RX_START) begin
                r_rx_start <= i_cfg_data;
            end
        end
    end

    // state update, once per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt  <= '0;
            r_load_ovf  <= 1'b0;
            r_send_len  <= '0;
            r_send_idx  <= '0;
            r_bit_pos   <= 4'd0;
            r_frame     <= 10'h200;
            r_tick_cnt  <= 16'd0;
            r_timer_run <= 1'b0;
            r_edge_en   <= 1'b1;
            r_line      <= 1'b1;
        end else if (s_accept) begin
            r_load_cnt  <= n_load_cnt;
            r_load_ovf  <= n_load_ovf;
            r_send_len  <= n_send_len;
            r_send_idx  <= n_send_idx;
            r_bit_pos   <= n_bit_pos;
            r_frame     <= n_frame;
            r_tick_cnt  <= n_timer_run ? n_tick_cnt : 16'd0;
            r_timer_run <= n_timer_run;
            r_edge_en   <= n_edge_en;
            r_line      <= n_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_first <= n_first;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out_ev   <= n_ev;
            r_out_rx   <= n_rx;
            r_out_line <= n_line;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_rx, r_out_line};
    assign o_m_tuser  = r_out_ev;

    // checks
    a_no_edge_while_sending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_send_len != '0) |-> (!r_edge_en && r_timer_run))
        else $error("edge detection enabled during a transmit burst");

    a_load_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_load_cnt <= DEPTH_C) && (r_send_idx <= r_send_len))
        else $error("buffer counters out of range");

    a_txdone_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && n_ev == u8trx_pkg::EV_TXDONE) |=> (r_send_len == '0 && !r_timer_run))
        else $error("transmit done reported without ending the burst");

    a_rx_only_on_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ev != u8trx_pkg::EV_RXBYTE) |-> (r_out_rx == 8'd0))
        else $error("receive data present without a received byte");

endmodule

[design/u8trx_txbuf.sv]
// Transmit byte buffer: one write port, one registered read port.
// Depends on nothing but its parameters.

module u8trx_txbuf #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
